// ----- hw/rtl/i2a_pkg.sv -----
package i2a_pkg;

   // Default build values for the top level parameters.
   localparam int SHORT_WIDTH_DEF     = 32;
   localparam int LONG_HEX_DIGITS_DEF = 16;

   // No conversion produces more characters than this.
   localparam int MAX_OUT = 16;

   // Request selector codes.
   localparam logic [2:0] CMD_CHAR     = 3'd0;
   localparam logic [2:0] CMD_SDEC     = 3'd1;
   localparam logic [2:0] CMD_UDEC     = 3'd2;
   localparam logic [2:0] CMD_HEX      = 3'd3;
   localparam logic [2:0] CMD_HEX_LONG = 3'd4;

   // Character codes.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] DIGIT_BASE = 8'd10;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] ascii_char;
      logic       last;
   } rsp_type;

   // Control handed from the sequencer to the character emitter.
   typedef struct packed {
      logic load;
      logic raw;
      logic neg;
      logic skip_zero;
   } emit_ctl_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_CONVERT,
      TOP_EMIT
   } top_state_type;

   typedef enum logic [2:0] {
      EM_IDLE,
      EM_RAW,
      EM_SIGN,
      EM_SKIP,
      EM_DIGIT
   } emit_state_type;

   // Uppercase hex character for one digit; decimal digits map the same way.
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] wide;
      wide = {4'd0, d};
      if (wide < DIGIT_BASE) begin
         digit_char = CHAR_ZERO + wide;
      end else begin
         digit_char = CHAR_A + wide - DIGIT_BASE;
      end
   endfunction

endpackage

// ----- hw/rtl/i2a_dabble.sv -----
module i2a_dabble #(
   parameter int WIDTH  = 32,
   parameter int DIGITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [WIDTH-1:0]      bin,
   output logic [DIGITS*4-1:0]   bcd,
   output logic                  done
);
   import i2a_pkg::*;

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0]    bin_ff, bin_in;
   logic [DIGITS*4-1:0] bcd_ff, bcd_in;
   logic [DIGITS*4-1:0] adj;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;

   // Shift-and-add-three: every digit at five or more gets three added
   // before the next binary bit is shifted in.
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                     : bcd_ff[i*4 +: 4];
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (load) begin
         bin_in = bin;
         bcd_in = '0;
         cnt_in = CNT_W'(WIDTH);
         run_in = 1'b1;
      end else if (run_ff) begin
         bcd_in  = {adj[DIGITS*4-2:0], bin_ff[WIDTH-1]};
         bin_in  = bin_ff << 1;
         cnt_in  = cnt_ff - CNT_W'(1);
         run_in  = (cnt_ff != CNT_W'(1));
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign bcd  = bcd_ff;
   assign done = done_ff;

   a_done_stops : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff && $past(run_ff))
      else $error("conversion finished without running");

endmodule

// ----- hw/rtl/i2a_emit.sv -----
module i2a_emit #(
   parameter int NDIG = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  i2a_pkg::emit_ctl_type     ctl,
   input  logic [NDIG*4-1:0]         digits,
   input  logic [$clog2(NDIG+1)-1:0] count,
   input  logic [7:0]                raw_char,
   output i2a_pkg::rsp_type          rsp,
   output logic                      strobe,
   output logic                      done
);
   import i2a_pkg::*;

   localparam int CNT_W  = $clog2(NDIG + 1);
   localparam int SENT_W = $clog2(MAX_OUT);

   emit_state_type      state_ff, state_in;
   logic [NDIG*4-1:0]   dig_ff, dig_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic [SENT_W-1:0]   sent_ff, sent_in;
   logic [7:0]          raw_ff, raw_in;
   rsp_type             rsp_ff, rsp_in;
   logic                strobe_ff, strobe_in;
   logic [3:0]          top_digit;
   logic                skippable;
   logic                last_char;
   logic                fin;

   assign top_digit = dig_ff[NDIG*4-1 -: 4];
   assign skippable = (top_digit == 4'd0) && (left_ff > CNT_W'(1));
   assign last_char = (left_ff == CNT_W'(1)) || (sent_ff == SENT_W'(MAX_OUT - 1));

   always_comb begin
      dig_in    = dig_ff;
      left_in   = left_ff;
      sent_in   = sent_ff;
      raw_in    = raw_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      fin       = 1'b0;
      case (state_ff)
         EM_IDLE: begin
            if (ctl.load) begin
               dig_in  = digits;
               left_in = count;
               sent_in = '0;
               raw_in  = raw_char;
            end
         end
         EM_RAW: begin
            rsp_in.ascii_char = raw_ff;
            rsp_in.last       = 1'b1;
            strobe_in         = 1'b1;
            fin               = 1'b1;
         end
         EM_SIGN: begin
            rsp_in.ascii_char = CHAR_MINUS;
            rsp_in.last       = 1'b0;
            strobe_in         = 1'b1;
            sent_in           = sent_ff + SENT_W'(1);
         end
         EM_SKIP, EM_DIGIT: begin
            dig_in  = dig_ff << 4;
            left_in = left_ff - CNT_W'(1);
            if (!(state_ff == EM_SKIP && skippable)) begin
               rsp_in.ascii_char = digit_char(top_digit);
               rsp_in.last       = last_char;
               strobe_in         = 1'b1;
               sent_in           = sent_ff + SENT_W'(1);
               fin               = last_char;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EM_IDLE: begin
            if (ctl.load) begin
               if (ctl.raw) begin
                  state_in = EM_RAW;
               end else if (ctl.neg) begin
                  state_in = EM_SIGN;
               end else if (ctl.skip_zero) begin
                  state_in = EM_SKIP;
               end else begin
                  state_in = EM_DIGIT;
               end
            end
         end
         EM_RAW: begin
            state_in = EM_IDLE;
         end
         EM_SIGN: begin
            state_in = EM_SKIP;
         end
         EM_SKIP: begin
            if (fin) begin
               state_in = EM_IDLE;
            end else if (!skippable) begin
               state_in = EM_DIGIT;
            end
         end
         EM_DIGIT: begin
            if (fin) begin
               state_in = EM_IDLE;
            end
         end
         default: begin
            state_in = EM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= EM_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff  <= dig_in;
      left_ff <= left_in;
      sent_ff <= sent_in;
      raw_ff  <= raw_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp    = rsp_ff;
   assign strobe = strobe_ff;
   assign done   = fin;

   a_more_follows : assert property (@(posedge clock) disable iff (reset)
      strobe_ff && !rsp_ff.last |-> state_ff != EM_IDLE)
      else $error("emitter went idle before the final character");

endmodule

// ----- hw/rtl/integer_to_ascii_formatter.sv -----
// Hex and character requests load the emitter as they transfer; each character is
// registered before it shows, and short hex skips leading zeros first. Decimal requests
// first run the BCD conversion, then send any minus sign before skipping leading zeros.
// From the first digit on, characters leave one per cycle. One request is taken at a
// time; busy drops as the final character is registered, so the next request can
// transfer as it shows. Reset is synchronous and returns to idle, no strobe pending.
module integer_to_ascii_formatter #(
   parameter int SHORT_WIDTH     = i2a_pkg::SHORT_WIDTH_DEF,
   parameter int LONG_HEX_DIGITS = i2a_pkg::LONG_HEX_DIGITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  i2a_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_strobe,
   output i2a_pkg::rsp_type rsp_data
);
   import i2a_pkg::*;

   // Digit counts: decimal digits of the largest word (floor(W*log10(2)) + 1),
   // hex digits of the word; the widest of these and LONG_HEX_DIGITS sizes the buffer.
   localparam int DEC_DIGITS = ((SHORT_WIDTH * 1233) >> 12) + 1;
   localparam int HEX_DIGITS = (SHORT_WIDTH + 3) / 4;
   localparam int NDIG_A     = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
   localparam int NDIG       = (NDIG_A > LONG_HEX_DIGITS) ? NDIG_A : LONG_HEX_DIGITS;
   localparam int CNT_W      = $clog2(NDIG + 1);
   // Left shifts that put the most significant digit at the top of the buffer.
   localparam int DEC_SHIFT  = 4 * (NDIG - DEC_DIGITS);
   localparam int HEX_SHIFT  = 4 * (NDIG - HEX_DIGITS);
   localparam int LONG_SHIFT = 4 * (NDIG - LONG_HEX_DIGITS);

   top_state_type             state_ff, state_in;
   logic                      neg_ff, neg_in;
   logic [SHORT_WIDTH-1:0]    word;
   logic [SHORT_WIDTH-1:0]    mag;
   logic                      word_neg;
   logic                      accept;
   logic                      dab_load;
   logic [DEC_DIGITS*4-1:0]   dab_bcd;
   logic                      dab_done;
   emit_ctl_type              em_ctl;
   logic [NDIG*4-1:0]         em_digits;
   logic [CNT_W-1:0]          em_count;
   logic                      em_done;

   assign accept   = start && !busy;
   assign word     = req_data.value[SHORT_WIDTH-1:0];
   assign word_neg = (req_data.cmd == CMD_SDEC) && word[SHORT_WIDTH-1];
   // The magnitude is taken as unsigned, so the most negative word converts cleanly.
   assign mag      = word_neg ? SHORT_WIDTH'(~word + 1'b1) : word;

   // The shared shift-and-add-three unit converts the decimal operand one bit per cycle.
   i2a_dabble #(
      .WIDTH  (SHORT_WIDTH),
      .DIGITS (DEC_DIGITS)
   ) u_dabble (
      .clock (clock),
      .reset (reset),
      .load  (dab_load),
      .bin   (mag),
      .bcd   (dab_bcd),
      .done  (dab_done)
   );

   // The emitter skips leading zeros where asked, then sends one character per cycle.
   i2a_emit #(
      .NDIG (NDIG)
   ) u_emit (
      .clock    (clock),
      .reset    (reset),
      .ctl      (em_ctl),
      .digits   (em_digits),
      .count    (em_count),
      .raw_char (req_data.value[7:0]),
      .rsp      (rsp_data),
      .strobe   (rsp_strobe),
      .done     (em_done)
   );

   // Sequencer outputs: which unit starts and what the emitter is loaded with.
   always_comb begin
      dab_load  = 1'b0;
      neg_in    = neg_ff;
      em_ctl    = '0;
      em_digits = '0;
      em_count  = '0;
      case (state_ff)
         TOP_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_CHAR: begin
                     em_ctl.load = 1'b1;
                     em_ctl.raw  = 1'b1;
                     em_count    = CNT_W'(1);
                  end
                  CMD_SDEC, CMD_UDEC: begin
                     dab_load = 1'b1;
                     neg_in   = word_neg;
                  end
                  CMD_HEX: begin
                     em_ctl.load      = 1'b1;
                     em_ctl.skip_zero = 1'b1;
                     em_digits        = (NDIG*4)'(word) << HEX_SHIFT;
                     em_count         = CNT_W'(HEX_DIGITS);
                  end
                  CMD_HEX_LONG: begin
                     em_ctl.load = 1'b1;
                     em_digits   = (NDIG*4)'(req_data.value[LONG_HEX_DIGITS*4-1:0])
                                   << LONG_SHIFT;
                     em_count    = CNT_W'(LONG_HEX_DIGITS);
                  end
                  default: begin
                     // Unused selectors are taken and produce nothing.
                  end
               endcase
            end
         end
         TOP_CONVERT: begin
            if (dab_done) begin
               em_ctl.load      = 1'b1;
               em_ctl.neg       = neg_ff;
               em_ctl.skip_zero = 1'b1;
               em_digits        = (NDIG*4)'(dab_bcd) << DEC_SHIFT;
               em_count         = CNT_W'(DEC_DIGITS);
            end
         end
         default: begin
         end
      endcase
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TOP_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_CHAR, CMD_HEX, CMD_HEX_LONG: state_in = TOP_EMIT;
                  CMD_SDEC, CMD_UDEC:              state_in = TOP_CONVERT;
                  default:                         state_in = TOP_IDLE;
               endcase
            end
         end
         TOP_CONVERT: begin
            if (dab_done) begin
               state_in = TOP_EMIT;
            end
         end
         TOP_EMIT: begin
            if (em_done) begin
               state_in = TOP_IDLE;
            end
         end
         default: begin
            state_in = TOP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TOP_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
   end

   assign busy = (state_ff != TOP_IDLE);

   // Every character comes from a conversion that was in progress.
   a_strobe_in_burst : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("character sent outside a conversion");

   // A decimal request holds the block busy while the conversion runs.
   a_decimal_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.cmd == CMD_SDEC || req_data.cmd == CMD_UDEC)
      |=> busy && !rsp_strobe)
      else $error("decimal request did not start a conversion");

   // The final character of a burst is never directly followed by another.
   a_gap_after_last : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |=> !rsp_strobe)
      else $error("character followed the final one without a new request");

endmodule
